// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

	typedef enum logic [1:0] {
		REQ_TIME   = 2'd0,
		REQ_PIN    = 2'd1,
		REQ_INJECT = 2'd2
	} bpc_req_kind_t;

	typedef enum logic [2:0] {
		EV_PTT_DOWN    = 3'd0,
		EV_PTT_UP      = 3'd1,
		EV_MODE_SINGLE = 3'd2,
		EV_MODE_DOUBLE = 3'd3,
		EV_MODE_LONG   = 3'd4
	} bpc_event_t;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_DOUBLE_GAP = 2'd1;
	localparam logic [1:0] REG_LONG_PRESS = 2'd2;

	localparam logic [15:0] DEBOUNCE_RST   = 16'd25;
	localparam logic [15:0] DOUBLE_GAP_RST = 16'd350;
	localparam logic [15:0] LONG_PRESS_RST = 16'd800;

	localparam int unsigned MAX_EVENTS = 3;

	typedef struct packed {
		logic [15:0] debounce_time;
		logic [15:0] double_gap_time;
		logic [15:0] long_press_time;
	} bpc_cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        button_index;
		logic        pin_released;
		logic [2:0]  injected_event;
		logic [31:0] now_ms;
	} bpc_req_t;

	typedef struct packed {
		logic [1:0]                  count;
		logic [MAX_EVENTS-1:0][2:0]  codes;
		logic                        ptt_held;
	} bpc_result_t;

endpackage

// ----- rtl/bpc_cfg_regs.sv -----
module bpc_cfg_regs
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output bpc_cfg_t    cfg
);

	logic     wr_en;
	bpc_cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_RST;
			cfg_q.double_gap_time <= DOUBLE_GAP_RST;
			cfg_q.long_press_time <= LONG_PRESS_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_DEBOUNCE:   cfg_q.debounce_time   <= pwdata[15:0];
				REG_DOUBLE_GAP: cfg_q.double_gap_time <= pwdata[15:0];
				REG_LONG_PRESS: cfg_q.long_press_time <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DEBOUNCE:   prdata = {16'd0, cfg_q.debounce_time};
			REG_DOUBLE_GAP: prdata = {16'd0, cfg_q.double_gap_time};
			REG_LONG_PRESS: prdata = {16'd0, cfg_q.long_press_time};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ----- rtl/bpc_classify.sv -----
module bpc_classify
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bpc_cfg_t    cfg,
	input  bpc_req_t    req,
	input  logic        advance,
	output bpc_result_t result
);

	logic [1:0]  rel_q;
	logic [31:0] edge_time_q [2];
	logic        ptt_phys_q, ptt_virt_q;
	logic [31:0] mode_down_q, mode_rel_time_q;
	logic        long_fired_q, single_pend_q;

	logic [1:0]  rel_n;
	logic [31:0] edge_time_n [2];
	logic        ptt_phys_n, ptt_virt_n;
	logic [31:0] mode_down_n, mode_rel_time_n;
	logic        long_fired_n, single_pend_n;

	logic        edge_ok, ev0_v, ev_long, ev_single;
	logic [2:0]  ev0_code;
	logic [31:0] dt_edge, dt_gap_old, dt_hold, dt_gap_new;

	always_comb begin
		rel_n           = rel_q;
		edge_time_n     = edge_time_q;
		ptt_phys_n      = ptt_phys_q;
		ptt_virt_n      = ptt_virt_q;
		mode_down_n     = mode_down_q;
		mode_rel_time_n = mode_rel_time_q;
		long_fired_n    = long_fired_q;
		single_pend_n   = single_pend_q;
		ev0_v           = 1'b0;
		ev0_code        = EV_PTT_DOWN;

		dt_edge    = req.now_ms - edge_time_q[req.button_index];
		dt_gap_old = req.now_ms - mode_rel_time_q;
		edge_ok    = (req.req_type == REQ_PIN) &&
			(dt_edge >= {16'd0, cfg.debounce_time}) &&
			(req.pin_released != rel_q[req.button_index]);

		if (edge_ok) begin
			rel_n[req.button_index]       = req.pin_released;
			edge_time_n[req.button_index] = req.now_ms;
			if (!req.button_index) begin
				ptt_phys_n = !req.pin_released;
				ev0_v      = 1'b1;
				ev0_code   = req.pin_released ? EV_PTT_UP : EV_PTT_DOWN;
			end else if (!req.pin_released) begin
				mode_down_n  = req.now_ms;
				long_fired_n = 1'b0;
			end else if (long_fired_q) begin
				// release after a long press closes it silently
				long_fired_n  = 1'b0;
				single_pend_n = 1'b0;
			end else if (single_pend_q && dt_gap_old <= {16'd0, cfg.double_gap_time}) begin
				single_pend_n = 1'b0;
				ev0_v         = 1'b1;
				ev0_code      = EV_MODE_DOUBLE;
			end else begin
				single_pend_n   = 1'b1;
				mode_rel_time_n = req.now_ms;
			end
		end else if (req.req_type == REQ_INJECT && req.injected_event <= EV_MODE_LONG) begin
			if (req.injected_event == EV_PTT_DOWN) ptt_virt_n = 1'b1;
			if (req.injected_event == EV_PTT_UP)   ptt_virt_n = 1'b0;
			ev0_v    = 1'b1;
			ev0_code = req.injected_event;
		end

		// timeouts, on the state left by the word itself
		dt_hold = req.now_ms - mode_down_n;
		ev_long = !rel_n[1] && !long_fired_n && (dt_hold >= {16'd0, cfg.long_press_time});
		if (ev_long) long_fired_n = 1'b1;

		dt_gap_new = req.now_ms - mode_rel_time_n;
		ev_single  = single_pend_n && (dt_gap_new > {16'd0, cfg.double_gap_time});
		if (ev_single) single_pend_n = 1'b0;

		result.count    = 2'({1'b0, ev0_v}) + 2'({1'b0, ev_long}) + 2'({1'b0, ev_single});
		result.codes[0] = ev0_v ? ev0_code : (ev_long ? EV_MODE_LONG : EV_MODE_SINGLE);
		result.codes[1] = (ev0_v && ev_long) ? EV_MODE_LONG : EV_MODE_SINGLE;
		result.codes[2] = EV_MODE_SINGLE;
		result.ptt_held = ptt_phys_n | ptt_virt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q           <= 2'b11;
			edge_time_q[0]  <= 32'd0;
			edge_time_q[1]  <= 32'd0;
			ptt_phys_q      <= 1'b0;
			ptt_virt_q      <= 1'b0;
			mode_down_q     <= 32'd0;
			mode_rel_time_q <= 32'd0;
			long_fired_q    <= 1'b0;
			single_pend_q   <= 1'b0;
		end else if (advance) begin
			rel_q           <= rel_n;
			edge_time_q     <= edge_time_n;
			ptt_phys_q      <= ptt_phys_n;
			ptt_virt_q      <= ptt_virt_n;
			mode_down_q     <= mode_down_n;
			mode_rel_time_q <= mode_rel_time_n;
			long_fired_q    <= long_fired_n;
			single_pend_q   <= single_pend_n;
		end
	end

endmodule

// ----- rtl/bpc_result_buf.sv -----
module bpc_result_buf
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bpc_result_t result,
	input  logic        load,
	output logic        free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	logic        valid_s2;
	bpc_result_t res_s2;
	logic [1:0]  idx_q;

	assign m_tvalid = valid_s2;
	assign m_tlast  = (idx_q == res_s2.count - 2'd1);
	assign m_tdata  = {4'd0, res_s2.ptt_held, res_s2.codes[idx_q]};
	assign free     = !valid_s2 || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (valid_s2 && m_tready) begin
			if (m_tlast) valid_s2 <= 1'b0;
			else         idx_q    <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_s2 <= result;
	end

endmodule

// ----- rtl/button_press_classifier_core.sv -----
// Button press classifier for a push-to-talk and a mode button.
// Input stream (s_*): one word per time check, pin change or injected event,
// each with its millisecond time. Output stream (m_*): classified events,
// zero to three per input word, the last of them marked by tlast; every event
// of a word carries the ptt held level left by that word.
// APB port: debounce, double-press gap and long-press hold times at byte
// addresses 0, 4 and 8; write these only while the block is idle.
// An accepted word is held in the input register; its events go to the output register.
// Throughput: one word per cycle while each word yields at most one event and
// the receiver takes it; a word with more events holds the output register until
// its last event is taken, and words yielding no event pass without touching it.
// The input register holds a word until the output register can take its
// events, so a stalled receiver backs up to s_tready with no word lost.
// Reset clears the button state and loads the default times (25, 350, 800 ms);
// s_tready is high as soon as reset is released, since the input register is empty.
module button_press_classifier_core
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // pin_released, injected_event[2:0], now_ms[31:0], zero pad
	input  logic [2:0]  s_tuser,  // req_type[1:0], button_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // event_code[2:0], ptt_held, zero pad
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bpc_cfg_t    cfg;
	bpc_req_t    req_s1;
	bpc_result_t result;
	logic        valid_s1, adv_s1, load_s2, s2_free;

	bpc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// word leaves s1 at once if it yields nothing, else when s2 is free
	assign adv_s1   = valid_s1 && (result.count == 2'd0 || s2_free);
	assign load_s2  = valid_s1 && result.count != 2'd0 && s2_free;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.req_type       <= s_tuser[1:0];
			req_s1.button_index   <= s_tuser[2];
			req_s1.pin_released   <= s_tdata[0];
			req_s1.injected_event <= s_tdata[3:1];
			req_s1.now_ms         <= s_tdata[35:4];
		end
	end

	bpc_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req_s1),
		.advance(adv_s1),
		.result (result)
	);

	bpc_result_buf u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.result  (result),
		.load    (load_s2),
		.free    (s2_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

`ifndef NO_ASSERTIONS
	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(req_s1))
		else $error("stalled input word lost or changed");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |-> !m_tvalid || (m_tready && m_tlast))
		else $error("output register overwritten before drained");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && !load_s2 |=> !m_tvalid)
		else $error("output still valid after last event taken");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input not ready while input register empty");
`endif

endmodule
